>>> rtl/rtsp_pkg.sv
// rtsp request framer package: phase codes, status codes, widths and defaults
// no dependencies
package rtsp_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF  = 63;
    localparam logic [7:0] HEADER_LIMIT_RESET = 8'd32;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LINE = 2'd1,
        ST_TOO_MANY = 2'd2,
        ST_BAD_LEN  = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        PH_METHOD  = 7'b0000001,
        PH_URI     = 7'b0000010,
        PH_REST    = 7'b0000100,
        PH_NAME    = 7'b0001000,
        PH_VALUE   = 7'b0010000,
        PH_DISCARD = 7'b0100000,
        PH_BODY    = 7'b1000000
    } phase_t;

    // lower-case header names, index past the end never matches
    function automatic logic [7:0] cseq_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "c";
            4'd1:    c = "s";
            4'd2:    c = "e";
            4'd3:    c = "q";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/rtsp_if.sv
// valid/ready channel interfaces for the rtsp request framer
// depends on rtsp_pkg for default widths
interface rtsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface rtsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_limit;
    modport source (output valid, output header_limit, input ready);
    modport sink (input valid, input header_limit, output ready);
endinterface

interface rtsp_result_if #(
    parameter int LENGTH_BITS = rtsp_pkg::LENGTH_BITS_DEF,
    parameter int VALUE_BITS  = rtsp_pkg::VALUE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [LENGTH_BITS-1:0] method_size;
    logic [LENGTH_BITS-1:0] uri_len;
    logic [7:0]             header_count;
    logic                   cseq_valid;
    logic [VALUE_BITS-1:0]  cseq;
    logic [VALUE_BITS-1:0]  content_length;
    logic [LENGTH_BITS-1:0] header_block_len;
    modport source (output valid, output status, output method_size, output uri_len,
        output header_count, output cseq_valid, output cseq, output content_length,
        output header_block_len, input ready);
    modport sink (input valid, input status, input method_size, input uri_len,
        input header_count, input cseq_valid, input cseq, input content_length,
        input header_block_len, output ready);
endinterface

>>> rtl/rtsp_request_framer_core.sv
// rtsp request framer top level: byte parser state and result register
// depends on rtsp_pkg and the channel interfaces in rtsp_if.sv

// One byte is taken per clock cycle unless stalled. Each byte updates the
// parser state with a single compare and a shift-add by ten on the value
// accumulator; the result of a header block (ending at the first CR LF CR LF)
// is loaded into an output register on the cycle its last byte is taken, and
// the input keeps accepting bytes while that register holds an untaken result,
// stalling only when a second result would need it. After a good result with
// a nonzero Content-Length that many body bytes are consumed without output.
module rtsp_request_framer_core #(
    parameter int LENGTH_BITS = rtsp_pkg::LENGTH_BITS_DEF,
    parameter int VALUE_BITS  = rtsp_pkg::VALUE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    rtsp_byte_if.sink     in_ch,
    rtsp_cfg_if.sink      cfg,
    rtsp_result_if.source out_ch
);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0]  VAL_MAX = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0]  DIV_TEN = VAL_MAX / 10;
    localparam logic [VALUE_BITS-1:0]  MOD_TEN = VAL_MAX % 10;

    logic [7:0] limit_reg;

    rtsp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]             sep_reg, sep_next;
    logic                   skip_reg, skip_next;
    logic                   pcr_reg, pcr_next;
    logic [3:0]             nidx_reg, nidx_next;
    logic [1:0]             flags_reg, flags_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic                   vok_reg, vok_next;
    logic                   vne_reg, vne_next;
    logic [LENGTH_BITS-1:0] mcnt_reg, mcnt_next;
    logic [LENGTH_BITS-1:0] ucnt_reg, ucnt_next;
    logic [LENGTH_BITS-1:0] bcnt_reg, bcnt_next;
    logic [7:0]             hcnt_reg, hcnt_next;
    logic [VALUE_BITS-1:0]  cseq_reg, cseq_next;
    logic                   cseen_reg, cseen_next;
    logic [VALUE_BITS-1:0]  len_reg, len_next;
    rtsp_pkg::status_t      err_reg, err_next;
    logic [VALUE_BITS-1:0]  body_reg, body_next;

    logic                   out_valid_reg;
    logic [1:0]             o_status_reg;
    logic [LENGTH_BITS-1:0] o_mlen_reg, o_ulen_reg, o_blen_reg;
    logic [7:0]             o_hcnt_reg;
    logic                   o_cv_reg;
    logic [VALUE_BITS-1:0]  o_cseq_reg, o_clen_reg;

    logic       take;
    logic       done;
    logic [7:0] b, lc;
    logic [VALUE_BITS-1:0] digit;
    logic       bad_line;
    logic [LENGTH_BITS-1:0] bcnt_inc;
    logic [VALUE_BITS-1:0] acc_x10;

    // only a byte that ends a block needs the result register free
    assign in_ch.ready = !out_valid_reg || out_ch.ready || !done;
    assign cfg.ready   = 1'b1;
    assign take        = in_ch.valid && in_ch.ready;
    assign b           = in_ch.byte_in;
    assign lc          = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    assign digit       = VALUE_BITS'(b - rtsp_pkg::CH_ZERO);
    assign acc_x10     = (acc_reg << 3) + (acc_reg << 1);
    assign bcnt_inc    = (bcnt_reg == LEN_MAX) ? bcnt_reg : bcnt_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;  sep_next = sep_reg;   skip_next = skip_reg;
        pcr_next = pcr_reg;      nidx_next = nidx_reg; flags_next = flags_reg;
        acc_next = acc_reg;      vok_next = vok_reg;   vne_next = vne_reg;
        mcnt_next = mcnt_reg;    ucnt_next = ucnt_reg; bcnt_next = bcnt_reg;
        hcnt_next = hcnt_reg;    cseq_next = cseq_reg; cseen_next = cseen_reg;
        len_next = len_reg;      err_next = err_reg;   body_next = body_reg;
        done = 1'b0;
        bad_line = 1'b0;
        if (phase_reg == rtsp_pkg::PH_BODY)
        begin
            if (body_reg <= VALUE_BITS'(1))
            begin
                phase_next = rtsp_pkg::PH_METHOD;
                body_next  = '0;
            end
            else
            begin
                body_next = body_reg - 1'b1;
            end
        end
        else
        begin
            bcnt_next = bcnt_inc;
            if (b == (sep_reg[0] ? rtsp_pkg::CH_LF : rtsp_pkg::CH_CR))
            begin
                if (sep_reg == 2'd3)
                    done = 1'b1;
                else
                    sep_next = sep_reg + 2'd1;
            end
            else
            begin
                sep_next = (b == rtsp_pkg::CH_CR) ? 2'd1 : 2'd0;
            end

            unique case (phase_reg)
                rtsp_pkg::PH_METHOD, rtsp_pkg::PH_URI:
                begin
                    if (b == rtsp_pkg::CH_SPACE)
                        phase_next = (phase_reg == rtsp_pkg::PH_METHOD) ?
                            rtsp_pkg::PH_URI : rtsp_pkg::PH_REST;
                    else if (b == rtsp_pkg::CH_LF)
                    begin
                        err_next = rtsp_pkg::ST_BAD_LINE;
                        phase_next = rtsp_pkg::PH_DISCARD;
                    end
                    else if (phase_reg == rtsp_pkg::PH_METHOD)
                        mcnt_next = (mcnt_reg == LEN_MAX) ? mcnt_reg : mcnt_reg + 1'b1;
                    else
                        ucnt_next = (ucnt_reg == LEN_MAX) ? ucnt_reg : ucnt_reg + 1'b1;
                end
                rtsp_pkg::PH_REST, rtsp_pkg::PH_NAME:
                begin
                    if (b == rtsp_pkg::CH_LF)
                    begin
                        phase_next = rtsp_pkg::PH_NAME;
                        skip_next = 1'b0; pcr_next = 1'b0; nidx_next = '0;
                        flags_next = 2'b11; acc_next = '0;
                        vok_next = 1'b0; vne_next = 1'b0;
                    end
                    else if (phase_reg == rtsp_pkg::PH_NAME && b == rtsp_pkg::CH_COLON)
                    begin
                        if (hcnt_reg >= limit_reg)
                        begin
                            err_next = rtsp_pkg::ST_TOO_MANY;
                            phase_next = rtsp_pkg::PH_DISCARD;
                        end
                        else
                        begin
                            hcnt_next = hcnt_reg + 8'd1;
                            flags_next = {flags_reg[1] && nidx_reg == 4'd14,
                                          flags_reg[0] && nidx_reg == 4'd4};
                            skip_next = 1'b1; pcr_next = 1'b0; acc_next = '0;
                            vok_next = 1'b1; vne_next = 1'b0;
                            phase_next = rtsp_pkg::PH_VALUE;
                        end
                    end
                    else if (phase_reg == rtsp_pkg::PH_NAME)
                    begin
                        if (nidx_reg >= 4'd4 || rtsp_pkg::cseq_char(nidx_reg) != lc)
                            flags_next[0] = 1'b0;
                        if (nidx_reg >= 4'd14 || rtsp_pkg::clen_char(nidx_reg) != lc)
                            flags_next[1] = 1'b0;
                        if (nidx_reg < 4'd15)
                            nidx_next = nidx_reg + 4'd1;
                    end
                end
                rtsp_pkg::PH_VALUE:
                begin
                    if (b == rtsp_pkg::CH_LF)
                    begin
                        if (flags_reg[0])
                        begin
                            if (vok_reg && vne_reg)
                            begin
                                cseq_next = acc_reg;
                                cseen_next = 1'b1;
                            end
                        end
                        else if (flags_reg[1] && vok_reg && vne_reg)
                            len_next = acc_reg;
                        if (!flags_reg[0] && flags_reg[1] && !(vok_reg && vne_reg))
                        begin
                            err_next = rtsp_pkg::ST_BAD_LEN;
                            phase_next = rtsp_pkg::PH_DISCARD;
                        end
                        else
                        begin
                            phase_next = rtsp_pkg::PH_NAME;
                            skip_next = 1'b0; pcr_next = 1'b0; nidx_next = '0;
                            flags_next = 2'b11; acc_next = '0;
                            vok_next = 1'b0; vne_next = 1'b0;
                        end
                    end
                    else if (!(skip_reg && (b == rtsp_pkg::CH_SPACE ||
                                            b == rtsp_pkg::CH_TAB)))
                    begin
                        skip_next = 1'b0;
                        if (b == rtsp_pkg::CH_CR)
                        begin
                            pcr_next = 1'b1;
                            if (pcr_reg)
                            begin
                                vne_next = 1'b1;
                                vok_next = 1'b0;
                            end
                        end
                        else
                        begin
                            pcr_next = 1'b0;
                            vne_next = 1'b1;
                            if (pcr_reg || b < rtsp_pkg::CH_ZERO || b > rtsp_pkg::CH_NINE)
                                vok_next = 1'b0;
                            else if (vok_reg)
                            begin
                                // overflow when acc > (max - d) / 10
                                if (acc_reg > DIV_TEN ||
                                    (acc_reg == DIV_TEN && digit > MOD_TEN))
                                    vok_next = 1'b0;
                                else
                                    acc_next = acc_x10 + digit;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            bad_line = (err_next == rtsp_pkg::ST_BAD_LINE);
            if (done)
            begin
                phase_next = (err_next == rtsp_pkg::ST_OK && len_next != '0) ?
                    rtsp_pkg::PH_BODY : rtsp_pkg::PH_METHOD;
                body_next = (err_next == rtsp_pkg::ST_OK) ? len_next : '0;
                sep_next = '0; skip_next = 1'b0; pcr_next = 1'b0; nidx_next = '0;
                flags_next = 2'b11; acc_next = '0; vok_next = 1'b0; vne_next = 1'b0;
                mcnt_next = '0; ucnt_next = '0; bcnt_next = '0; hcnt_next = '0;
                cseq_next = '0; cseen_next = 1'b0; len_next = '0;
                err_next = rtsp_pkg::ST_OK;
            end
        end
    end

    // body end returns to a fresh message; counters are already clear then
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= rtsp_pkg::HEADER_LIMIT_RESET;
            phase_reg <= rtsp_pkg::PH_METHOD;
            sep_reg <= '0; skip_reg <= 1'b0; pcr_reg <= 1'b0; nidx_reg <= '0;
            flags_reg <= 2'b11; acc_reg <= '0; vok_reg <= 1'b0; vne_reg <= 1'b0;
            mcnt_reg <= '0; ucnt_reg <= '0; bcnt_reg <= '0; hcnt_reg <= '0;
            cseq_reg <= '0; cseen_reg <= 1'b0; len_reg <= '0;
            err_reg <= rtsp_pkg::ST_OK; body_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                limit_reg <= cfg.header_limit;
            if (take)
            begin
                phase_reg <= phase_next; sep_reg <= sep_next; skip_reg <= skip_next;
                pcr_reg <= pcr_next; nidx_reg <= nidx_next; flags_reg <= flags_next;
                acc_reg <= acc_next; vok_reg <= vok_next; vne_reg <= vne_next;
                mcnt_reg <= mcnt_next; ucnt_reg <= ucnt_next; bcnt_reg <= bcnt_next;
                hcnt_reg <= hcnt_next; cseq_reg <= cseq_next; cseen_reg <= cseen_next;
                len_reg <= len_next; err_reg <= err_next; body_reg <= body_next;
            end
            if (take && done)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload from the state before clearing; the final LF of a block
    // leaves these fields untouched
    always_ff @(posedge clk)
    begin
        if (take && done)
        begin
            o_status_reg <= err_reg;
            o_mlen_reg <= bad_line ? '0 : mcnt_reg;
            o_ulen_reg <= bad_line ? '0 : ucnt_reg;
            o_hcnt_reg <= bad_line ? '0 : hcnt_reg;
            o_cv_reg   <= !bad_line && cseen_reg;
            o_cseq_reg <= (!bad_line && cseen_reg) ? cseq_reg : '0;
            o_clen_reg <= (err_reg == rtsp_pkg::ST_OK) ? len_reg : '0;
            o_blen_reg <= bcnt_inc;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.status           = o_status_reg;
    assign out_ch.method_size      = o_mlen_reg;
    assign out_ch.uri_len          = o_ulen_reg;
    assign out_ch.header_count     = o_hcnt_reg;
    assign out_ch.cseq_valid       = o_cv_reg;
    assign out_ch.cseq             = o_cseq_reg;
    assign out_ch.content_length   = o_clen_reg;
    assign out_ch.header_block_len = o_blen_reg;

    a_sep_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rtsp_pkg::PH_BODY |-> body_reg != '0)
        else $error("body phase with zero remaining");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg)
        else $error("result dropped while stalled");
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        take && done && err_reg != rtsp_pkg::ST_BAD_LINE |=> o_hcnt_reg <= $past(limit_reg))
        else $error("header count above limit");
endmodule

>>> test/tb_rtsp_request_framer_core.sv
// testbench for rtsp_request_framer_core: byte stream in, one result per header block out
// depends on rtsp_pkg and the channel interfaces in rtl/rtsp_if.sv
module tb_rtsp_request_framer_core;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] method_size;
        logic [15:0] uri_len;
        logic [7:0]  header_count;
        logic        cseq_valid;
        logic [62:0] cseq;
        logic [62:0] content_length;
        logic [15:0] header_block_len;
    } framer_result_t;

    localparam logic [63:0] VALUE_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [15:0] LEN_MAX   = 16'hffff;

    logic clk;
    logic rst_n;

    rtsp_byte_if   in_if ();
    rtsp_cfg_if    cfg_if ();
    rtsp_result_if out_if ();

    rtsp_request_framer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .cfg    (cfg_if),
        .out_ch (out_if)
    );

    // predictor state
    logic [7:0]  limit_reg;
    logic [1:0]  p_sep;
    rtsp_pkg::phase_t p_phase;
    logic        p_skip_blanks;
    logic        p_pending_cr;
    logic [3:0]  p_name_idx;
    logic [1:0]  p_name_flags;
    logic [63:0] p_acc;
    logic        p_val_ok;
    logic        p_val_nonempty;
    logic [15:0] p_method_cnt;
    logic [15:0] p_uri_cnt;
    logic [15:0] p_block_cnt;
    logic [7:0]  p_hdr_cnt;
    logic [62:0] p_cseq;
    logic        p_cseq_seen;
    logic [62:0] p_length;
    logic [1:0]  p_err;
    logic [62:0] p_body_left;

    framer_result_t pending_results[$];

    int mismatches;
    int results_seen;
    int bytes_sent;
    int burst_left;
    int tx_gap_max;
    int rx_mode;
    int rx_cycle;
    int hold_request;
    int hold_left;
    string cseq_name;
    string clen_name;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("timeout after %0d results", results_seen);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == LEN_MAX) ? v : v + 16'd1;
    endfunction

    function void start_line();
        p_skip_blanks  = 1'b0;
        p_pending_cr   = 1'b0;
        p_name_idx     = '0;
        p_name_flags   = 2'b11;
        p_acc          = '0;
        p_val_ok       = 1'b0;
        p_val_nonempty = 1'b0;
    endfunction

    function void new_message();
        start_line();
        p_sep       = '0;
        p_phase     = rtsp_pkg::PH_METHOD;
        p_method_cnt = '0;
        p_uri_cnt   = '0;
        p_block_cnt = '0;
        p_hdr_cnt   = '0;
        p_cseq      = '0;
        p_cseq_seen = 1'b0;
        p_length    = '0;
        p_err       = rtsp_pkg::ST_OK;
        p_body_left = '0;
    endfunction

    function void value_byte(logic [7:0] b);
        logic [63:0] d;
        if (p_skip_blanks && (b == rtsp_pkg::CH_SPACE || b == rtsp_pkg::CH_TAB))
            return;
        p_skip_blanks = 1'b0;
        if (p_pending_cr)
        begin
            p_pending_cr   = 1'b0;
            p_val_nonempty = 1'b1;
            p_val_ok       = 1'b0;
        end
        if (b == rtsp_pkg::CH_CR)
        begin
            p_pending_cr = 1'b1;
            return;
        end
        p_val_nonempty = 1'b1;
        if (b < rtsp_pkg::CH_ZERO || b > rtsp_pkg::CH_NINE)
            p_val_ok = 1'b0;
        else if (p_val_ok)
        begin
            d = 64'(b - rtsp_pkg::CH_ZERO);
            if (p_acc > (VALUE_MAX - d) / 10)
                p_val_ok = 1'b0;
            else
                p_acc = p_acc * 10 + d;
        end
    endfunction

    function void name_byte(logic [7:0] b);
        logic [7:0] c;
        c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (p_name_idx >= 4 || cseq_name[p_name_idx] != c)
            p_name_flags &= 2'b10;
        if (p_name_idx >= 14 || clen_name[p_name_idx] != c)
            p_name_flags &= 2'b01;
        if (p_name_idx < 15)
            p_name_idx++;
    endfunction

    function void colon_byte();
        logic [1:0] f;
        f = '0;
        if (p_hdr_cnt >= limit_reg)
        begin
            p_err   = rtsp_pkg::ST_TOO_MANY;
            p_phase = rtsp_pkg::PH_DISCARD;
            return;
        end
        p_hdr_cnt++;
        if (p_name_flags[0] && p_name_idx == 4)
            f[0] = 1'b1;
        if (p_name_flags[1] && p_name_idx == 14)
            f[1] = 1'b1;
        p_name_flags   = f;
        p_skip_blanks  = 1'b1;
        p_pending_cr   = 1'b0;
        p_acc          = '0;
        p_val_ok       = 1'b1;
        p_val_nonempty = 1'b0;
        p_phase        = rtsp_pkg::PH_VALUE;
    endfunction

    function void value_line_end();
        logic good;
        good = p_val_ok && p_val_nonempty;
        if (p_name_flags[0])
        begin
            if (good)
            begin
                p_cseq      = p_acc[62:0];
                p_cseq_seen = 1'b1;
            end
        end
        else if (p_name_flags[1])
        begin
            if (good)
                p_length = p_acc[62:0];
            else
            begin
                p_err   = rtsp_pkg::ST_BAD_LEN;
                p_phase = rtsp_pkg::PH_DISCARD;
                return;
            end
        end
        start_line();
        p_phase = rtsp_pkg::PH_NAME;
    endfunction

    // advance the framer prediction by one accepted byte
    function void frame_byte(logic [7:0] b);
        logic done;
        logic bad_line;
        logic [62:0] body;
        framer_result_t r;
        if (p_phase == rtsp_pkg::PH_BODY)
        begin
            if (p_body_left > 0)
                p_body_left--;
            if (p_body_left == 0)
                new_message();
            return;
        end
        p_block_cnt = sat_inc(p_block_cnt);
        done = 1'b0;
        if (b == (p_sep[0] ? rtsp_pkg::CH_LF : rtsp_pkg::CH_CR))
        begin
            if (p_sep == 2'd3)
                done = 1'b1;
            else
                p_sep++;
        end
        else
            p_sep = (b == rtsp_pkg::CH_CR) ? 2'd1 : 2'd0;

        case (p_phase)
            rtsp_pkg::PH_METHOD:
                if (b == rtsp_pkg::CH_SPACE)
                    p_phase = rtsp_pkg::PH_URI;
                else if (b == rtsp_pkg::CH_LF)
                begin
                    p_err   = rtsp_pkg::ST_BAD_LINE;
                    p_phase = rtsp_pkg::PH_DISCARD;
                end
                else
                    p_method_cnt = sat_inc(p_method_cnt);
            rtsp_pkg::PH_URI:
                if (b == rtsp_pkg::CH_SPACE)
                    p_phase = rtsp_pkg::PH_REST;
                else if (b == rtsp_pkg::CH_LF)
                begin
                    p_err   = rtsp_pkg::ST_BAD_LINE;
                    p_phase = rtsp_pkg::PH_DISCARD;
                end
                else
                    p_uri_cnt = sat_inc(p_uri_cnt);
            rtsp_pkg::PH_REST:
                if (b == rtsp_pkg::CH_LF)
                begin
                    start_line();
                    p_phase = rtsp_pkg::PH_NAME;
                end
            rtsp_pkg::PH_NAME:
                if (b == rtsp_pkg::CH_LF)
                    start_line();
                else if (b == rtsp_pkg::CH_COLON)
                    colon_byte();
                else
                    name_byte(b);
            rtsp_pkg::PH_VALUE:
                if (b == rtsp_pkg::CH_LF)
                    value_line_end();
                else
                    value_byte(b);
            default:
                ;
        endcase

        if (!done)
            return;
        bad_line           = (p_err == rtsp_pkg::ST_BAD_LINE);
        r.status           = p_err;
        r.method_size      = bad_line ? '0 : p_method_cnt;
        r.uri_len          = bad_line ? '0 : p_uri_cnt;
        r.header_count     = bad_line ? '0 : p_hdr_cnt;
        r.cseq_valid       = !bad_line && p_cseq_seen;
        r.cseq             = (!bad_line && p_cseq_seen) ? p_cseq : '0;
        r.content_length   = (p_err == rtsp_pkg::ST_OK) ? p_length : '0;
        r.header_block_len = p_block_cnt;
        pending_results.push_back(r);
        body = p_length;
        if (p_err == rtsp_pkg::ST_OK && body > 0)
        begin
            new_message();
            p_body_left = body;
            p_phase     = rtsp_pkg::PH_BODY;
        end
        else
            new_message();
    endfunction

    // result side: check each transfer and apply the stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        framer_result_t e;
        logic ok;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            rx_cycle = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result, status %0d", out_if.status);
                end
                else
                begin
                    e = pending_results.pop_front();
                    ok = (out_if.status == e.status) && (out_if.method_size == e.method_size)
                        && (out_if.uri_len == e.uri_len)
                        && (out_if.header_count == e.header_count)
                        && (out_if.cseq_valid == e.cseq_valid) && (out_if.cseq == e.cseq)
                        && (out_if.content_length == e.content_length)
                        && (out_if.header_block_len == e.header_block_len);
                    if (!ok)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d mismatch", results_seen);
                            $display("  exp st=%0d m=%0d u=%0d h=%0d cv=%0d cs=%0d cl=%0d b=%0d",
                                e.status, e.method_size, e.uri_len, e.header_count,
                                e.cseq_valid, e.cseq, e.content_length, e.header_block_len);
                            $display("  got st=%0d m=%0d u=%0d h=%0d cv=%0d cs=%0d cl=%0d b=%0d",
                                out_if.status, out_if.method_size, out_if.uri_len,
                                out_if.header_count, out_if.cseq_valid, out_if.cseq,
                                out_if.content_length, out_if.header_block_len);
                        end
                    end
                end
            end
            rx_cycle++;
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else
                case (rx_mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    default: out_if.ready <= ((rx_cycle % 11) < 4);
                endcase
        end
    end

    // send one byte, with bursts and random gaps, and predict it once it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
            if (gap > 0)
            begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_if.valid   <= 1'b1;
        in_if.byte_in <= b;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        frame_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // terminate any partial block and run out any body so the next request starts clean
    task automatic settle_stream();
        while (!(p_phase == rtsp_pkg::PH_METHOD && p_block_cnt == 0 && p_sep == 0))
        begin
            if (p_phase == rtsp_pkg::PH_BODY)
                send_byte($urandom_range(0, 255));
            else
                send_byte(p_sep[0] ? rtsp_pkg::CH_LF : rtsp_pkg::CH_CR);
        end
    endtask

    task automatic wait_results();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_results();
        cfg_if.valid        <= 1'b1;
        cfg_if.header_limit <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        limit_reg = v;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic string flip_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if ((r[i] >= "a" && r[i] <= "z") || (r[i] >= "A" && r[i] <= "Z"))
                if ($urandom_range(0, 1))
                    r[i] = r[i] ^ 8'h20;
        return r;
    endfunction

    function automatic string blanks();
        string r;
        r = "";
        repeat ($urandom_range(0, 3))
            r = {r, ($urandom_range(0, 1) ? " " : "\t")};
        return r;
    endfunction

    function automatic string token(input int n);
        string r;
        byte c;
        r = "";
        repeat (n)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // arbitrary byte, but no separators of the request line
                do
                    c = $urandom_range(0, 255);
                while (c == rtsp_pkg::CH_SPACE || c == rtsp_pkg::CH_LF ||
                       c == rtsp_pkg::CH_CR);
            end
            else
                c = $urandom_range("a", "z");
            r = {r, string'(c)};
        end
        return r;
    endfunction

    function automatic string number_text();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 9);
            1: v = VALUE_MAX;
            2: return "9223372036854775808";
            3: return "99999999999999999999";
            default: v = {$urandom, $urandom} & VALUE_MAX;
        endcase
        return $sformatf("%0d", v);
    endfunction

    function automatic string header_line();
        case ($urandom_range(0, 9))
            0, 1, 2: return {flip_case("CSeq"), ":", blanks(), number_text(), "\r\n"};
            3, 4:    return {flip_case("Content-Length"), ":", blanks(),
                             $sformatf("%0d", $urandom_range(0, 12)), "\r\n"};
            5:       return {"Content-Length:", blanks(),
                             ($urandom_range(0, 1) ? "" : "1x"), "\r\n"};
            6:       return {"CSeq:", blanks(), token($urandom_range(0, 3)), "\r\n"};
            7:       return {"junk line ", token(3), "\r\n"};
            8:       return {flip_case("CSeqx"), ": 5\r\n"};
            default: return {"Session:", blanks(), token($urandom_range(0, 8)), "\r\n"};
        endcase
    endfunction

    task automatic random_request();
        string s;
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 16)
        begin
            s = {token($urandom_range(0, 10)), " ", token($urandom_range(0, 16)),
                 " RTSP/1.0\r\n"};
            repeat ($urandom_range(0, 6))
                s = {s, header_line()};
            s = {s, "\r\n"};
        end
        else if (kind < 18)
            s = {token($urandom_range(0, 8)), ($urandom_range(0, 1) ? " x" : ""),
                 "\r\nCSeq: 3\r\n\r\n"};
        else
        begin
            s = "";
            repeat ($urandom_range(1, 40))
                s = {s, string'(byte'($urandom_range(0, 255)))};
        end
        send_text(s);
        settle_stream();
    endtask

    task automatic test_directed();
        send_text("DESCRIBE rtsp://h/a RTSP/1.0\r\nCSeq: 1\r\n\r\n");
        send_text("ANNOUNCE u RTSP/1.0\r\ncontent-LENGTH: 5\r\n\r\n");
        settle_stream();
        send_text("GET\r\n\r\n");
        send_text("A B\r\nCSeq: 4\r\n\r\n");
        send_text(" x \r\n\r\n");
        send_text("P u v\r\ncSeQ:\t  42\r\n\r\n");
        send_text("P u v\r\nCSeq: 9223372036854775807\r\n\r\n");
        send_text("P u v\r\nCSeq: 9223372036854775808\r\nCSeq: 7\r\n\r\n");
        send_text("P u v\r\nCSeq: 12\r\r\n\r\n");
        send_text("P u v\r\nContent-Length: 1x\r\nCSeq: 2\r\n\r\n");
        send_text("P u v\r\nContent-Length:\r\n\r\n");
        send_text("P u v\r\nContent-Length: 3\r\nContent-Length: 0\r\n\r\n");
        send_text("P u v\r\nno colon here\r\nCSeqX: 3\r\n\n\r\n\r\n");
        send_text({"P ", string'(8'h00), string'(8'hff), " v\r\n\r\n"});
        settle_stream();
    endtask

    task automatic test_header_limit();
        logic [7:0] limits[4] = '{8'd0, 8'd1, 8'd255, 8'd2};
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            send_text("OPTIONS * RTSP/1.0\r\nA: 1\r\nB: 2\r\nCSeq: 8\r\n\r\n");
            random_request();
        end
        write_limit(8'($urandom_range(3, 40)));
        random_request();
        write_limit(rtsp_pkg::HEADER_LIMIT_RESET);
    endtask

    task automatic test_random();
        while (bytes_sent < 1550)
        begin
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            rx_mode = $urandom_range(0, 2);
            random_request();
        end
    endtask

    task automatic test_backpressure();
        // a result waits behind a stalled receiver; the next block end stalls the input
        tx_gap_max = 0;
        hold_request = 400;
        repeat (6)
            send_text("SETUP u RTSP/1.0\r\nCSeq: 6\r\n\r\n");
        tx_gap_max = 3;
        wait_results();
        send_text("PLAY u RTSP/1.0\r\nContent-Length: 2\r\n\r\nab");
        settle_stream();
    endtask

    initial
    begin
        cseq_name = "cseq";
        clen_name = "content-length";
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.byte_in = '0;
        cfg_if.valid = 1'b0;
        cfg_if.header_limit = '0;
        mismatches = 0;
        results_seen = 0;
        bytes_sent = 0;
        burst_left = 0;
        tx_gap_max = 3;
        rx_mode = 1;
        hold_request = 0;
        limit_reg = rtsp_pkg::HEADER_LIMIT_RESET;
        new_message();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_header_limit();
        test_backpressure();
        test_random();

        wait_results();
        repeat (10) @(posedge clk);
        $display("%0d request bytes sent, %0d header blocks checked", bytes_sent, results_seen);
        $display("covered limits 0..255, all statuses, body skip, stalls and full input");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rtsp_pkg.sv
rtl/rtsp_if.sv
rtl/rtsp_request_framer_core.sv
test/tb_rtsp_request_framer_core.sv
